// ===== hdl/srtm_pkg.sv =====
// Shared types and constants for the stride range table membership unit.
`timescale 1ns / 1ps

package srtm_pkg;

    // Code point and field widths
    localparam int CP_W        = 21;
    localparam int IDX_W       = 10;
    localparam int CFG_W       = 11;
    localparam int CFG_ADDR_W  = 1;
    localparam int CNT_W       = 5;
    localparam int S_TDATA_W   = 96;
    localparam int M_TDATA_W   = 8;

    // Request kinds carried on s_tuser
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_ENTRY = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_ENTRY_COUNT = 1'b1;

    typedef logic [CP_W-1:0] cp_t;

    // One table entry as held in the range store
    typedef struct packed {
        cp_t stride;
        cp_t high;
        cp_t low;
    } entry_t;

    // Remainder unit request and response
    typedef struct packed {
        logic start;
        cp_t  dividend;
        cp_t  divisor;
    } rem_req_t;

    typedef struct packed {
        logic done;
        logic zero;
    } rem_rsp_t;

    // Search sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_CMP,
        S_REM,
        S_RESULT
    } search_state_t;

endpackage

// ===== hdl/srtm_store.sv =====
// Range store: single write port, single registered read port memory.
`timescale 1ns / 1ps

module srtm_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  srtm_pkg::entry_t wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output srtm_pkg::entry_t rd_data
);
    import srtm_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Entry writes from the input channel.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, enabled by rd_en.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/srtm_rem.sv =====
// Bit-serial restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps

module srtm_rem (
    input  logic               aclk,
    input  logic               aresetn,
    input  srtm_pkg::rem_req_t req,
    output srtm_pkg::rem_rsp_t rsp
);
    import srtm_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    cp_t              rem_reg, rem_next;
    cp_t              shf_reg, shf_next;
    cp_t              dvs_reg, dvs_next;
    logic [CP_W:0]    trial;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, shf_reg[CP_W-1]};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            shf_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = CP_W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_next = trial[CP_W-1:0];
            end
            shf_next = {shf_reg[CP_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(CP_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and partial remainder registers.
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.zero = (rem_reg == '0);

    // A finished remainder always follows a busy cycle.
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("remainder done without a preceding busy cycle");

    // The sequencer never restarts the unit mid-operation.
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("remainder unit started while busy");

    // The step counter stays inside the dividend width.
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cnt_reg < CNT_W'(CP_W)))
        else $error("remainder step counter out of range");

endmodule

// ===== hdl/srtm_search.sv =====
// Binary search sequencer over the range store with stride check.
`timescale 1ns / 1ps

module srtm_search #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  srtm_pkg::cp_t                 query_code,
    input  logic [srtm_pkg::CFG_W-1:0]    first_entry,
    input  logic [srtm_pkg::CFG_W-1:0]    entry_count,
    input  logic                          out_free,
    output logic                          rd_en,
    output logic [AW-1:0]                 rd_addr,
    input  srtm_pkg::entry_t              rd_data,
    output srtm_pkg::rem_req_t            rem_req,
    input  srtm_pkg::rem_rsp_t            rem_rsp,
    output logic                          idle,
    output logic                          res_valid,
    output logic                          res_member
);
    import srtm_pkg::*;

    localparam int PW = AW + 1;
    localparam int BW = (CFG_W > PW) ? CFG_W : PW;

    search_state_t state_reg, state_next;
    logic [PW-1:0] lo_reg, lo_next;
    logic [PW-1:0] hi_reg, hi_next;
    cp_t           code_reg, code_next;
    logic          res_reg, res_next;

    logic [BW-1:0] fe_w, ec_w, dp_w, hi_clamp;
    logic          empty;
    logic [PW:0]   sum;
    logic [PW-1:0] mid;
    logic          hit, below, more;
    logic [PW-1:0] lo_upd, hi_upd;

    // Window bounds, midpoint and the probe decision.
    always_comb begin
        fe_w     = BW'(first_entry);
        ec_w     = BW'(entry_count);
        dp_w     = BW'(DEPTH);
        hi_clamp = (ec_w > dp_w) ? dp_w : ec_w;
        empty    = (fe_w >= hi_clamp);
        sum      = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid      = sum[PW:1];
        hit      = (rd_data.low <= code_reg) && (code_reg <= rd_data.high);
        below    = (code_reg < rd_data.low);
        lo_upd   = below ? lo_reg : mid + 1'b1;
        hi_upd   = below ? mid : hi_reg;
        more     = (lo_upd < hi_upd);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = empty ? S_RESULT : S_ADDR;
                end
            end
            S_ADDR: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (hit) begin
                    state_next = S_REM;
                end else if (more) begin
                    state_next = S_ADDR;
                end else begin
                    state_next = S_RESULT;
                end
            end
            S_REM: begin
                if (rem_rsp.done) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Search window, query and answer updates.
    always_comb begin
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        code_next = code_reg;
        res_next  = res_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    lo_next   = PW'(fe_w);
                    hi_next   = PW'(hi_clamp);
                    code_next = query_code;
                    res_next  = 1'b0;
                end
            end
            S_CMP: begin
                if (!hit) begin
                    lo_next  = lo_upd;
                    hi_next  = hi_upd;
                    res_next = 1'b0;
                end
            end
            S_REM: begin
                if (rem_rsp.done) begin
                    res_next = rem_rsp.zero;
                end
            end
            default: begin
            end
        endcase
    end

    // Outputs.
    always_comb begin
        rd_en            = (state_reg == S_ADDR);
        rd_addr          = mid[AW-1:0];
        rem_req.start    = (state_reg == S_CMP) && hit;
        rem_req.dividend = code_reg - rd_data.low;
        rem_req.divisor  = (rd_data.stride == '0) ? CP_W'(1) : rd_data.stride;
        idle             = (state_reg == S_IDLE);
        res_valid        = (state_reg == S_RESULT);
        res_member       = res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        code_reg <= code_next;
        res_reg  <= res_next;
    end

    // Every probe addresses a slot inside the table.
    a_probe_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (mid < PW'(DEPTH)))
        else $error("search probe outside the table");

    // A compare only happens on a non-empty window.
    a_window_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP) |-> (lo_reg < hi_reg))
        else $error("compare on an empty search window");

    // A new query only arrives while the sequencer is idle.
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> (state_reg == S_IDLE))
        else $error("query started while a search is running");

endmodule

// ===== hdl/stride_range_table_membership_unit.sv =====
// An entry write gives no result. A query searches the window with P probes, where
// P is at most log2 of the window plus one; each probe is one store read and compare,
// and a hit then runs the bit-serial remainder unit before the result. One item is
// handled at a time; the next is taken once the search sequencer is idle, also while a result waits.
// Reset (aresetn, synchronous, active low) clears both registers and the control logic.
`timescale 1ns / 1ps

module stride_range_table_membership_unit #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // entry_index[9:0], range_low[30:10], range_high[51:31], range_stride[72:52],
    // query_code[93:73], zero fill above
    input  logic [srtm_pkg::S_TDATA_W-1:0]       s_tdata,
    // req_type[0]
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // is_member[0], zero fill above
    output logic [srtm_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [srtm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [srtm_pkg::CFG_W-1:0]           cfg_wdata
);
    import srtm_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int XW = ((IDX_W > AW) ? IDX_W : AW) + 1;

    logic [CFG_W-1:0] first_entry_reg, entry_count_reg;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             member_reg, member_next;

    logic [IDX_W-1:0] in_index;
    entry_t           in_entry;
    cp_t              in_code;
    logic [XW-1:0]    widx;
    logic             s_hs, wr_ok, wr_en, start, out_free;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    entry_t           rd_data;
    rem_req_t         rem_req;
    rem_rsp_t         rem_rsp;
    logic             idle, res_valid, res_member;

    // Input transaction decode.
    always_comb begin
        s_hs            = s_tvalid && s_tready;
        in_index        = s_tdata[9:0];
        in_entry.low    = s_tdata[30:10];
        in_entry.high   = s_tdata[51:31];
        in_entry.stride = s_tdata[72:52];
        in_code         = s_tdata[93:73];
        widx            = XW'(in_index);
        wr_ok           = (widx < XW'(TABLE_DEPTH));
        wr_en           = s_hs && (s_tuser == REQ_WRITE) && wr_ok;
        start           = s_hs && (s_tuser == REQ_QUERY);
        out_free        = !m_tvalid_reg || m_tready;
    end

    assign s_tready = idle;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_entry_reg <= '0;
            entry_count_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_FIRST_ENTRY: first_entry_reg <= cfg_wdata;
                REG_ENTRY_COUNT: entry_count_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    srtm_store #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (widx[AW-1:0]),
        .wr_data (in_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    srtm_rem u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rem_req),
        .rsp     (rem_rsp)
    );

    srtm_search #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_search (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .query_code  (in_code),
        .first_entry (first_entry_reg),
        .entry_count (entry_count_reg),
        .out_free    (out_free),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .rem_req     (rem_req),
        .rem_rsp     (rem_rsp),
        .idle        (idle),
        .res_valid   (res_valid),
        .res_member  (res_member)
    );

    // Output register: takes a result whenever the previous one has gone.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        member_next   = member_reg;
        if (res_valid && out_free) begin
            m_tvalid_next = 1'b1;
            member_next   = res_member;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        member_reg <= member_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - 1)'(0), member_reg};

    // A query transaction closes the input until its search is done.
    a_query_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_hs && (s_tuser == REQ_QUERY)) |=> !s_tready)
        else $error("input accepted during a running search");

    // A result appears on the output only after the search offered one.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(res_valid))
        else $error("output valid without a search result");

    // A result that cannot move to the output register is held.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !out_free) |=> res_valid)
        else $error("search result dropped while the output was full");

endmodule

// ===== tb/srtm_membership_checker.sv =====
// Checker for the stride range table unit: tracks the table, predicts membership, compares.
`timescale 1ns / 1ps

module srtm_membership_checker #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [srtm_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [srtm_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [srtm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [srtm_pkg::CFG_W-1:0]      cfg_wdata,
    output int                              fail_count,
    output int                              pending_results,
    output int                              member_count
);
    import srtm_pkg::*;

    // One outstanding answer, kept with the code point that was asked about.
    typedef struct {
        cp_t  code;
        logic member;
    } membership_t;

    // Private copy of the range table and the search window.
    cp_t              low_tab    [TABLE_DEPTH];
    cp_t              high_tab   [TABLE_DEPTH];
    cp_t              stride_tab [TABLE_DEPTH];
    logic [CFG_W-1:0] window_first;
    logic [CFG_W-1:0] window_count;

    membership_t      answers_due [$];
    int               n_fail;
    int               n_member;

    // Binary search over the window; a hit is a member when it falls on the stride.
    function automatic logic lookup_member(input cp_t code);
        int  lo;
        int  hi;
        int  mid;
        cp_t step;
        lo = int'(window_first);
        hi = (int'(window_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(window_count);
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (low_tab[mid] <= code && code <= high_tab[mid]) begin
                step = (stride_tab[mid] == '0) ? cp_t'(1) : stride_tab[mid];
                return ((code - low_tab[mid]) % step) == 0;
            end
            if (code < low_tab[mid]) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        return 1'b0;
    endfunction

    // Only the first ten failures are printed; the rest are just counted.
    task automatic flag_failure(input string msg);
        n_fail++;
        if (n_fail <= 10) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // Follow register writes and transactions on both channels at each clock edge.
    always @(posedge aclk) begin
        membership_t          head;
        logic [M_TDATA_W-1:0] want;
        if (!aresetn) begin
            window_first = '0;
            window_count = '0;
            answers_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_FIRST_ENTRY: window_first = cfg_wdata;
                    REG_ENTRY_COUNT: window_count = cfg_wdata;
                    default: ;
                endcase
            end

            // Results are matched before new requests, so an older answer is never
            // confused with one that is only just being asked for.
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    flag_failure($sformatf("result 0x%02h with no query outstanding", m_tdata));
                end else begin
                    head = answers_due.pop_front();
                    want = M_TDATA_W'(head.member);
                    if (m_tdata !== want) begin
                        flag_failure($sformatf(
                            "code 0x%06h: expected is_member 0x%02h, got 0x%02h",
                            head.code, want, m_tdata));
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                if (s_tuser == REQ_WRITE) begin
                    low_tab[s_tdata[9:0]]    = s_tdata[30:10];
                    high_tab[s_tdata[9:0]]   = s_tdata[51:31];
                    stride_tab[s_tdata[9:0]] = s_tdata[72:52];
                end else begin
                    head.code   = s_tdata[93:73];
                    head.member = lookup_member(head.code);
                    if (head.member) begin
                        n_member++;
                    end
                    answers_due.push_back(head);
                end
            end
        end
        fail_count      <= n_fail;
        pending_results <= answers_due.size();
        member_count    <= n_member;
    end

endmodule

// ===== tb/stride_range_table_membership_unit_tb.sv =====
// Top of the stride range table testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module stride_range_table_membership_unit_tb;

    import srtm_pkg::*;

    localparam int TABLE_DEPTH   = 1024;
    localparam int CP_MAX        = 1114111;
    localparam int CFG_MAX       = 2047;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int TOTAL_ITEMS   = 2000;
    localparam int CYCLE_LIMIT   = 1000000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    int chk_fail_count;
    int chk_pending;
    int chk_members;

    // Flow control knobs and run statistics.
    int   tx_idle_pct = 28;
    int   rx_idle_pct = 61;
    logic hold_ask    = 1'b0;
    int   hold_left   = 0;
    logic hold_done   = 1'b0;
    int   cycle_count = 0;
    int   item_count  = 0;
    int   write_count = 0;
    int   query_count = 0;
    int   window_sets = 0;

    // Stimulus-side view of the table and window, used only to aim queries.
    int tbl_low    [TABLE_DEPTH];
    int tbl_high   [TABLE_DEPTH];
    int tbl_stride [TABLE_DEPTH];
    int win_first  = 0;
    int win_stop   = 0;

    always #4 aclk = ~aclk;

    stride_range_table_membership_unit #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    srtm_membership_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_membership_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (chk_fail_count),
        .pending_results (chk_pending),
        .member_count    (chk_members)
    );

    // Watchdog: a run that overstays the limit is a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("stride_range_table_membership_unit verification failed");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold-off when asked for.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_ask && !hold_done) begin
            m_tready <= 1'b0;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Offer one transaction, with random idle cycles first, and wait until it is taken.
    task automatic push_req(input logic kind, input logic [S_TDATA_W-1:0] data);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        item_count++;
    endtask

    task automatic put_entry(input int idx, input int lo, input int hi, input int st);
        tbl_low[idx]    = lo;
        tbl_high[idx]   = hi;
        tbl_stride[idx] = st;
        write_count++;
        push_req(REQ_WRITE, {2'b00, CP_W'($urandom_range(0, CP_MAX)), CP_W'(st),
                             CP_W'(hi), CP_W'(lo), IDX_W'(idx)});
    endtask

    // Fields other than the code point carry noise on a query.
    task automatic ask(input int code);
        query_count++;
        push_req(REQ_QUERY, {2'b00, CP_W'(code), CP_W'($urandom_range(0, CP_MAX)),
                             CP_W'($urandom_range(0, CP_MAX)),
                             CP_W'($urandom_range(0, CP_MAX)),
                             IDX_W'($urandom_range(0, TABLE_DEPTH - 1))});
    endtask

    // Let every outstanding answer arrive and the sequencer go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (chk_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Both registers are written back to back while the block is idle.
    task automatic set_window(input int first, input int count);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_FIRST_ENTRY;
        cfg_wdata <= CFG_W'(first);
        @(posedge aclk);
        cfg_addr  <= REG_ENTRY_COUNT;
        cfg_wdata <= CFG_W'(count);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        win_first = first;
        win_stop  = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
        window_sets++;
    endtask

    // Fill the window with sorted, disjoint ranges spread over the code space.
    task automatic load_table(input int first, input int stop);
        int n;
        int gap;
        int lo;
        int len;
        int st;
        n = stop - first;
        if (n <= 0) return;
        gap = (CP_MAX + 1) / n;
        for (int i = 0; i < n; i++) begin
            lo  = i * gap + $urandom_range(0, gap / 4);
            len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, gap / 2);
            case ($urandom_range(0, 9))
                0, 1:    st = 0;
                2, 3:    st = 1;
                4, 5, 6: st = $urandom_range(2, 16);
                7, 8:    st = $urandom_range(0, len + 1);
                default: st = $urandom_range(0, CP_MAX);
            endcase
            put_entry(first + i, lo, lo + len, st);
        end
    endtask

    // Aim most often at stride points of loaded ranges, then near misses, edges and random codes.
    function automatic int pick_code();
        int slot;
        int lo;
        int hi;
        int step;
        int k;
        int roll;
        roll = $urandom_range(0, 99);
        if (win_stop <= win_first || roll < 12) return $urandom_range(0, CP_MAX);
        slot = $urandom_range(win_first, win_stop - 1);
        lo   = tbl_low[slot];
        hi   = tbl_high[slot];
        step = (tbl_stride[slot] == 0) ? 1 : tbl_stride[slot];
        k    = (hi >= lo) ? $urandom_range(0, (hi - lo) / step) : 0;
        if (roll < 60) return lo + k * step;
        if (roll < 75) return (lo + k * step < CP_MAX) ? lo + k * step + 1 : lo;
        if (roll < 85) return hi;
        if (roll < 92) return (lo > 0) ? lo - 1 : lo;
        return (hi < CP_MAX) ? hi + 1 : hi;
    endfunction

    initial begin
        int directed_items;
        int mode;
        int roll;
        int n;
        int first;
        int count;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty window straight out of reset.
        ask(0);
        ask(CP_MAX);

        // One range over the whole code space with a zero stride.
        settle();
        set_window(0, 1);
        put_entry(0, 0, CP_MAX, 0);
        ask(0);
        ask(CP_MAX);
        ask(21'h0AAAAA);

        // Stride of seven: on the stride, off it, just below and just above the range.
        put_entry(0, 5, 100, 7);
        put_entry(1, 500, 600, 1);
        put_entry(2, 10, 20, 1);
        ask(12);
        ask(13);
        ask(4);
        ask(101);

        // Unsorted table: the search result stands whatever the table says.
        settle();
        set_window(0, 3);
        ask(15);
        ask(550);

        // Top slot with the largest values, a stride wider than the range.
        put_entry(TABLE_DEPTH - 1, CP_MAX, CP_MAX, CP_MAX);
        settle();
        set_window(TABLE_DEPTH - 1, TABLE_DEPTH);
        ask(CP_MAX);
        ask(CP_MAX - 1);

        // Count beyond the depth is clamped; a first entry past the clamped count empties the window.
        settle();
        set_window(TABLE_DEPTH - 1, CFG_MAX);
        ask(CP_MAX);
        settle();
        set_window(CFG_MAX, CFG_MAX);
        ask(CP_MAX);
        directed_items = item_count;

        // Random phases: new window, fresh sorted table, then mostly queries.
        while (item_count < TOTAL_ITEMS) begin
            mode = (item_count - directed_items) * 3 / (TOTAL_ITEMS - directed_items);
            settle();
            case (mode)
                0: begin
                    tx_idle_pct = 28;
                    rx_idle_pct <= 61;
                end
                1: begin
                    tx_idle_pct = 61;
                    rx_idle_pct <= 28;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                    hold_ask    <= 1'b1;
                end
            endcase

            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                first = $urandom_range(0, CFG_MAX);
                count = $urandom_range(0, first);
            end else begin
                n     = (roll < 13) ? $urandom_range(33, 256) : $urandom_range(1, 32);
                first = ($urandom_range(0, 9) == 0) ? TABLE_DEPTH - n
                                                    : $urandom_range(0, TABLE_DEPTH - n);
                count = first + n;
                if (count == TABLE_DEPTH && $urandom_range(0, 1) == 1) begin
                    count = $urandom_range(TABLE_DEPTH, CFG_MAX);
                end
            end
            set_window(first, count);
            load_table(win_first, win_stop);

            // A few stray writes land anywhere, sometimes disturbing the order.
            repeat ($urandom_range(30, 80)) begin
                if ($urandom_range(0, 99) < 8) begin
                    put_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, CP_MAX),
                              $urandom_range(0, CP_MAX), $urandom_range(0, CP_MAX));
                end else begin
                    ask(pick_code());
                end
            end
        end

        settle();
        $display("Covered %0d table writes and %0d queries (%0d members) over %0d windows,",
                 write_count, query_count, chk_members, window_sets);
        $display("with idling on either side, none at all, and one long result hold-off.");
        if (chk_fail_count == 0 && chk_pending == 0) begin
            $display("stride_range_table_membership_unit verification clean");
        end else begin
            $display("stride_range_table_membership_unit verification failed");
        end
        $finish;
    end

endmodule
